@@ hw/rtl/wff_pkg.sv @@
// Shared types and constants for the wire-format field filter.
`default_nettype none
package wff_pkg;

  localparam int unsigned TAG_BUFFER_BYTES = 10;
  localparam int unsigned TAG_IDX_W        = $clog2(TAG_BUFFER_BYTES);
  localparam int unsigned FIELD_W          = 32;
  localparam int unsigned VARINT_W         = 64;
  localparam int unsigned SHIFT_W          = 7;
  localparam int unsigned VARINT_BITS      = 7;
  localparam int unsigned WT_W             = 3;
  localparam int unsigned FNUM_PAD_W       = VARINT_W - WT_W - FIELD_W;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);

  localparam logic [WT_W-1:0] WT_VARINT = 3'd0;
  localparam logic [WT_W-1:0] WT_FIXED8 = 3'd1;
  localparam logic [WT_W-1:0] WT_LENGTH = 3'd2;
  localparam logic [WT_W-1:0] WT_FIXED4 = 3'd5;

  localparam logic [VARINT_W-1:0] FIXED8_BYTES = 64'd8;
  localparam logic [VARINT_W-1:0] FIXED4_BYTES = 64'd4;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_VARINT,
    PH_LEN,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_FLUSH,
    CMD_DATA,
    CMD_ABORT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [7:0]           data;
    logic [TAG_IDX_W-1:0] idx;
    logic                 done;
  } cmd_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       done;
    logic       run_last;
  } result_t;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ABORT = 1'b1;

endpackage
`default_nettype wire

@@ hw/rtl/wff_front.sv @@
// Front end: parses tags and values, decides keep or drop, issues commands.
`default_nettype none
module wff_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [wff_pkg::FIELD_W-1:0]  cfg_field_to_delete_i,
  input  wire logic                         valid_i,
  input  wire logic [7:0]                   in_byte_i,
  input  wire logic                         chunk_last_i,
  output wff_pkg::cmd_t                     cmd_o,
  output logic                              cmd_push_o
);

  wff_pkg::phase_e                     phase_q, phase_d;
  logic [wff_pkg::TAG_IDX_W-1:0]       tag_cnt_q, tag_cnt_d;
  logic [wff_pkg::VARINT_W-1:0]        acc_q, acc_d;
  logic [wff_pkg::SHIFT_W-1:0]         shift_q, shift_d;
  logic [wff_pkg::VARINT_W-1:0]        rem_q, rem_d;
  logic                                keep_q, keep_d;
  logic [wff_pkg::FIELD_W-1:0]         ftd_q;

  logic                                more;
  logic [wff_pkg::VARINT_W-1:0]        shifted;
  logic [wff_pkg::VARINT_W-1:0]        acc_new;
  logic [wff_pkg::SHIFT_W-1:0]         shift_new;
  logic                                overlong;
  logic [wff_pkg::WT_W-1:0]            wt;
  logic                                good;
  logic                                keep_new;
  logic [wff_pkg::VARINT_W-1:0]        rem_dec;
  logic                                rem_end;
  logic                                fail;

  always_comb begin
    more      = in_byte_i[7];
    shifted   = {{(wff_pkg::VARINT_W-7){1'b0}}, in_byte_i[6:0]} << shift_q[5:0];
    acc_new   = acc_q | shifted;
    shift_new = shift_q + wff_pkg::SHIFT_W'(wff_pkg::VARINT_BITS);
    overlong  = shift_new[wff_pkg::SHIFT_W-1];
    wt        = acc_new[wff_pkg::WT_W-1:0];
    good      = wt inside {wff_pkg::WT_VARINT, wff_pkg::WT_FIXED8,
                           wff_pkg::WT_LENGTH, wff_pkg::WT_FIXED4};
    keep_new  = acc_new[wff_pkg::VARINT_W-1:wff_pkg::WT_W] !=
                {{wff_pkg::FNUM_PAD_W{1'b0}}, ftd_q};
    rem_dec   = (rem_q != '0) ? rem_q - wff_pkg::VARINT_W'(1) : rem_q;
    rem_end   = (rem_q[wff_pkg::VARINT_W-1:1] == '0);

    phase_d   = phase_q;
    tag_cnt_d = tag_cnt_q;
    acc_d     = acc_q;
    shift_d   = shift_q;
    rem_d     = rem_q;
    keep_d    = keep_q;
    fail      = 1'b0;

    cmd_push_o  = 1'b0;
    cmd_o.kind  = wff_pkg::CMD_HOLD;
    cmd_o.data  = in_byte_i;
    cmd_o.idx   = tag_cnt_q;
    cmd_o.done  = 1'b0;

    if (valid_i) begin
      case (phase_q)
        wff_pkg::PH_TAG: begin
          if (more) begin
            if (overlong || chunk_last_i) begin
              fail = 1'b1;
            end else begin
              cmd_push_o = 1'b1;
              tag_cnt_d  = tag_cnt_q + wff_pkg::TAG_IDX_W'(1);
              acc_d      = acc_new;
              shift_d    = shift_new;
            end
          end else if (chunk_last_i || !good) begin
            fail = 1'b1;
          end else begin
            keep_d     = keep_new;
            cmd_push_o = keep_new;
            cmd_o.kind = wff_pkg::CMD_FLUSH;
            tag_cnt_d  = '0;
            acc_d      = '0;
            shift_d    = '0;
            case (wt)
              wff_pkg::WT_VARINT: phase_d = wff_pkg::PH_VARINT;
              wff_pkg::WT_LENGTH: phase_d = wff_pkg::PH_LEN;
              wff_pkg::WT_FIXED8: begin
                rem_d   = wff_pkg::FIXED8_BYTES;
                phase_d = wff_pkg::PH_PAYLOAD;
              end
              default: begin
                rem_d   = wff_pkg::FIXED4_BYTES;
                phase_d = wff_pkg::PH_PAYLOAD;
              end
            endcase
          end
        end
        wff_pkg::PH_VARINT: begin
          cmd_o.kind = wff_pkg::CMD_DATA;
          if (!more) begin
            cmd_push_o = keep_q;
            cmd_o.done = 1'b1;
            phase_d    = wff_pkg::PH_TAG;
            keep_d     = 1'b0;
            shift_d    = '0;
          end else if (overlong || chunk_last_i) begin
            fail = 1'b1;
          end else begin
            cmd_push_o = keep_q;
            shift_d    = shift_new;
          end
        end
        wff_pkg::PH_LEN: begin
          cmd_o.kind = wff_pkg::CMD_DATA;
          if (!more) begin
            if (acc_new == '0) begin
              cmd_push_o = keep_q;
              cmd_o.done = 1'b1;
              phase_d    = wff_pkg::PH_TAG;
              keep_d     = 1'b0;
              acc_d      = '0;
              shift_d    = '0;
            end else if (chunk_last_i) begin
              fail = 1'b1;
            end else begin
              cmd_push_o = keep_q;
              rem_d      = acc_new;
              acc_d      = '0;
              shift_d    = '0;
              phase_d    = wff_pkg::PH_PAYLOAD;
            end
          end else if (overlong || chunk_last_i) begin
            fail = 1'b1;
          end else begin
            cmd_push_o = keep_q;
            acc_d      = acc_new;
            shift_d    = shift_new;
          end
        end
        wff_pkg::PH_PAYLOAD: begin
          cmd_o.kind = wff_pkg::CMD_DATA;
          if (rem_end) begin
            cmd_push_o = keep_q;
            cmd_o.done = 1'b1;
            phase_d    = wff_pkg::PH_TAG;
            keep_d     = 1'b0;
            rem_d      = '0;
          end else if (chunk_last_i) begin
            fail = 1'b1;
          end else begin
            cmd_push_o = keep_q;
            rem_d      = rem_dec;
          end
        end
        default: begin
          if (chunk_last_i) begin
            phase_d = wff_pkg::PH_TAG;
          end
        end
      endcase

      if (fail) begin
        cmd_push_o = 1'b1;
        cmd_o.kind = wff_pkg::CMD_ABORT;
        cmd_o.done = 1'b0;
        tag_cnt_d  = '0;
        acc_d      = '0;
        shift_d    = '0;
        rem_d      = '0;
        keep_d     = 1'b0;
        phase_d    = chunk_last_i ? wff_pkg::PH_TAG : wff_pkg::PH_DISCARD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wff_pkg::PH_TAG;
      tag_cnt_q <= '0;
      acc_q     <= '0;
      shift_q   <= '0;
      rem_q     <= '0;
      keep_q    <= 1'b0;
      ftd_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      tag_cnt_q <= tag_cnt_d;
      acc_q     <= acc_d;
      shift_q   <= shift_d;
      rem_q     <= rem_d;
      keep_q    <= keep_d;
      if (cfg_we_i) begin
        ftd_q <= cfg_field_to_delete_i;
      end
    end
  end

  a_tag_cnt_only_in_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != wff_pkg::PH_TAG |-> tag_cnt_q == '0)
    else $error("tag count left over outside tag phase");

  a_tag_shift_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wff_pkg::PH_TAG |-> !shift_q[wff_pkg::SHIFT_W-1] &&
                                   tag_cnt_q < wff_pkg::TAG_IDX_W'(wff_pkg::TAG_BUFFER_BYTES))
    else $error("tag varint ran past its limit");

endmodule
`default_nettype wire

@@ hw/rtl/wff_cmd_fifo.sv @@
// Command queue between the parser and the result stage.
`default_nettype none
module wff_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire wff_pkg::cmd_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output wff_pkg::cmd_t      data_o,
  output logic               valid_o
);

  wff_pkg::cmd_t                     mem_q [wff_pkg::CMD_DEPTH];
  logic [wff_pkg::CMD_PTR_W-1:0]     wr_q, rd_q;
  logic [wff_pkg::CMD_PTR_W:0]       cnt_q;
  logic                              do_push, do_pop;

  assign full_o  = (cnt_q == (wff_pkg::CMD_PTR_W+1)'(wff_pkg::CMD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + wff_pkg::CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + wff_pkg::CMD_PTR_W'(1);
      end
      cnt_q <= cnt_q + (wff_pkg::CMD_PTR_W+1)'(do_push) - (wff_pkg::CMD_PTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");

endmodule
`default_nettype wire

@@ hw/rtl/wff_back.sv @@
// Result stage: holds tag bytes, expands commands into items, output queue.
`default_nettype none
module wff_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire wff_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output wff_pkg::result_t   res_o
);

  logic [7:0]                        tag_q [wff_pkg::TAG_BUFFER_BYTES];
  logic                              busy_q, busy_d;
  logic [wff_pkg::TAG_IDX_W-1:0]     pos_q, pos_d;
  logic [wff_pkg::TAG_IDX_W-1:0]     end_q, end_d;

  wff_pkg::result_t                  out_mem_q [wff_pkg::OUT_DEPTH];
  logic [wff_pkg::OUT_PTR_W-1:0]     wr_q, rd_q;
  logic [wff_pkg::OUT_PTR_W:0]       cnt_q;
  logic                              out_full;
  logic                              do_pop;

  logic                              emit;
  wff_pkg::result_t                  res;
  logic                              tag_we;

  assign out_full = (cnt_q == (wff_pkg::OUT_PTR_W+1)'(wff_pkg::OUT_DEPTH));
  assign empty_o  = (cnt_q == '0);
  assign res_o    = out_mem_q[rd_q];
  assign do_pop   = pop_i && !empty_o;

  always_comb begin
    busy_d       = busy_q;
    pos_d        = pos_q;
    end_d        = end_q;
    emit         = 1'b0;
    cmd_pop_o    = 1'b0;
    tag_we       = 1'b0;
    res.kind     = wff_pkg::KIND_DATA;
    res.data     = tag_q[pos_q];
    res.done     = 1'b0;
    res.run_last = (pos_q == end_q);

    if (busy_q) begin
      emit = 1'b1;
      if (!out_full) begin
        pos_d  = pos_q + wff_pkg::TAG_IDX_W'(1);
        busy_d = (pos_q != end_q);
      end
    end else if (cmd_valid_i) begin
      case (cmd_i.kind)
        wff_pkg::CMD_HOLD: begin
          cmd_pop_o = 1'b1;
          tag_we    = 1'b1;
        end
        wff_pkg::CMD_FLUSH: begin
          emit = 1'b1;
          if (cmd_i.idx == '0) begin
            res.data     = cmd_i.data;
            res.run_last = 1'b1;
          end else begin
            res.data     = tag_q[0];
            res.run_last = 1'b0;
          end
          if (!out_full) begin
            cmd_pop_o = 1'b1;
            tag_we    = 1'b1;
            busy_d    = (cmd_i.idx != '0);
            pos_d     = wff_pkg::TAG_IDX_W'(1);
            end_d     = cmd_i.idx;
          end
        end
        wff_pkg::CMD_DATA: begin
          emit         = 1'b1;
          res.data     = cmd_i.data;
          res.done     = cmd_i.done;
          res.run_last = 1'b1;
          cmd_pop_o    = !out_full;
        end
        default: begin
          emit         = 1'b1;
          res.kind     = wff_pkg::KIND_ABORT;
          res.data     = '0;
          res.run_last = 1'b1;
          cmd_pop_o    = !out_full;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
      end_q  <= '0;
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
      end_q  <= end_d;
      if (emit && !out_full) begin
        wr_q <= wr_q + wff_pkg::OUT_PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + wff_pkg::OUT_PTR_W'(1);
      end
      cnt_q <= cnt_q + (wff_pkg::OUT_PTR_W+1)'(emit && !out_full)
                     - (wff_pkg::OUT_PTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_q[cmd_i.idx] <= cmd_i.data;
    end
    if (emit && !out_full) begin
      out_mem_q[wr_q] <= res;
    end
  end

  a_flush_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pos_q <= end_q &&
               end_q < wff_pkg::TAG_IDX_W'(wff_pkg::TAG_BUFFER_BYTES))
    else $error("tag flush position out of range");

  a_no_cmd_during_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !cmd_pop_o)
    else $error("command taken while a tag flush is in progress");

endmodule
`default_nettype wire

@@ hw/rtl/wire_format_field_filter.sv @@
// Top level: wire-format field filter with queue-style input and result ports.
// Path: parse, command queue, expand, output queue; both queues are registered.
// Throughput: one byte per cycle unless full; an n-byte tag gives the result stage n-1
// hold commands storing its bytes and, when kept, a flush emitting them at one item per
// cycle given room; the 4-entry command queue absorbs the gap and full holds the rest.
// Reset: asynchronous active low; parser waits for a tag, queues empty, register 0.
`default_nettype none
module wire_format_field_filter (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [wff_pkg::FIELD_W-1:0]  cfg_field_to_delete_i,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [7:0]                   in_byte_i,
  input  wire logic                         chunk_last_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              out_kind_o,
  output logic [7:0]                        out_byte_o,
  output logic                              entry_done_o,
  output logic                              run_last_o
);

  wff_pkg::cmd_t    front_cmd;
  logic             front_push;
  wff_pkg::cmd_t    q_cmd;
  logic             q_valid;
  logic             q_pop;
  wff_pkg::result_t res;
  logic             accept;

  assign accept = push && !full;

  wff_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_field_to_delete_i (cfg_field_to_delete_i),
    .valid_i               (accept),
    .in_byte_i             (in_byte_i),
    .chunk_last_i          (chunk_last_i),
    .cmd_o                 (front_cmd),
    .cmd_push_o            (front_push)
  );

  wff_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_cmd),
    .valid_o (q_valid)
  );

  wff_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign out_kind_o   = res.kind;
  assign out_byte_o   = res.data;
  assign entry_done_o = res.done;
  assign run_last_o   = res.run_last;

endmodule
`default_nettype wire
